FILE: rtl/mnnd_pkg.sv
// shared constants, codes and control structs for the mean nearest-neighbor distance block
// no dependencies
package mnnd_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIM    = 8;

    localparam int COORD_W    = 24;
    localparam int AVG_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = 48;
    localparam int QCNT_W     = 11;
    localparam int AXIS_W     = 2;
    localparam int DIM_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int ITER_W     = 6;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_TERM_W  = 2 * DIFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = 1'd1;

    localparam logic [AXIS_W-1:0] AXIS_ALL    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_FIRST  = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_SECOND = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_SPARE  = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic take;
        logic clr_wr;
        logic item_write;
        logic rd;
        logic first_k;
        logic last_k;
        logic first_p;
        logic sqrt_load;
        logic sqrt_step;
        logic accum;
        logic div_load;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic end_point;
        logic end_set;
        logic ci_zero;
        logic room;
        logic ref_empty;
        logic empty;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: rtl/mnnd_if.sv
// valid/ready channel interfaces for coordinate items and result items
// depends on mnnd_pkg
interface mnnd_in_if;
    import mnnd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [COORD_W-1:0]  coord_value;
    logic                       end_of_point;
    logic                       end_of_set;

    modport source (output valid, mode, coord_value, end_of_point, end_of_set, input ready);
    modport sink   (input valid, mode, coord_value, end_of_point, end_of_set, output ready);
endinterface

interface mnnd_out_if;
    import mnnd_pkg::*;
    logic                valid;
    logic                ready;
    logic [AVG_W-1:0]    avg_distance;
    logic [STATUS_W-1:0] status;

    modport source (output valid, avg_distance, status, input ready);
    modport sink   (input valid, avg_distance, status, output ready);
endinterface

FILE: rtl/mnnd_ctrl.sv
// controller state machine: item handling, row clearing, reference scan, sqrt and divide sequencing
// depends on mnnd_pkg
module mnnd_ctrl #(
    parameter int MAX_POINTS = mnnd_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIM    = mnnd_pkg::DEF_MAX_DIM
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  mnnd_pkg::t_dp_stat                         i_stat,
    input  logic [$clog2(MAX_POINTS+1)-1:0]            i_ref_cnt,
    input  logic [$clog2(MAX_DIM+1)-1:0]               i_k_lo,
    input  logic [$clog2(MAX_DIM+1)-1:0]               i_k_hi,
    output mnnd_pkg::t_dp_cmd                          o_cmd,
    output logic [$clog2(MAX_DIM+1)-1:0]               o_k,
    output logic [$clog2(MAX_POINTS*MAX_DIM)-1:0]      o_scan_addr
);
    import mnnd_pkg::*;

    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int KW     = $clog2(MAX_DIM + 1);
    localparam int AW     = $clog2(MAX_POINTS * MAX_DIM);
    localparam int SQ_RAW = 2 * DIFF_W - 1 + $clog2(MAX_DIM);
    localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
    localparam int RW     = SQ_W / 2;
    localparam int DRAIN_CYC = 4;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECIDE    = 14'b00000000000010,
        S_CLEAR     = 14'b00000000000100,
        S_WRITE     = 14'b00000000001000,
        S_START     = 14'b00000000010000,
        S_SCAN      = 14'b00000000100000,
        S_DRAIN     = 14'b00000001000000,
        S_SQRT_LOAD = 14'b00000010000000,
        S_SQRT      = 14'b00000100000000,
        S_ACCUM     = 14'b00001000000000,
        S_CHECK     = 14'b00010000000000,
        S_DIV_LOAD  = 14'b00100000000000,
        S_DIV       = 14'b01000000000000,
        S_EMIT      = 14'b10000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [KW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_p, n_p;
    logic [AW-1:0]   r_base, n_base;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic            last_k;
    logic            last_p;

    assign last_k      = (r_k + KW'(1)) == i_k_hi;
    assign last_p      = (r_p + CW'(1)) == i_ref_cnt;
    assign o_k         = r_k;
    assign o_scan_addr = r_base + AW'(r_k);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_p        = r_p;
        n_base     = r_base;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_k = '0;
                // a reference point starts: zero its whole row first
                if (!i_stat.mode && i_stat.room && i_stat.ci_zero) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_k == KW'(MAX_DIM - 1)) begin
                    n_state = S_WRITE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_WRITE: begin
                o_cmd.item_write = 1'b1;
                if (i_stat.end_point && i_stat.mode) begin
                    n_state = S_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                n_k    = i_k_lo;
                n_p    = '0;
                n_base = '0;
                if (i_stat.ref_empty) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.first_k = (r_k == i_k_lo);
                o_cmd.last_k  = last_k;
                o_cmd.first_p = (r_p == '0);
                if (last_k) begin
                    n_k    = i_k_lo;
                    n_p    = r_p + CW'(1);
                    n_base = r_base + AW'(MAX_DIM);
                    if (last_p) begin
                        n_cnt   = '0;
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DRAIN: begin
                // wait for the distance pipeline to settle the minimum
                if (r_cnt == ITER_W'(DRAIN_CYC - 1)) begin
                    n_state = S_SQRT_LOAD;
                end else begin
                    n_cnt = r_cnt + ITER_W'(1);
                end
            end
            S_SQRT_LOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == ITER_W'(RW - 1)) begin
                    n_state = S_ACCUM;
                end else begin
                    n_cnt = r_cnt + ITER_W'(1);
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.end_set) begin
                    n_state = i_stat.empty ? S_EMIT : S_DIV_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == ITER_W'(SUM_W - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + ITER_W'(1);
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_p     <= '0;
            r_base  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_p     <= n_p;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/mnnd_dp.sv
// datapath: item latch, reference store, query buffer, distance pipeline,
// bit-serial square root, running sum, bit-serial divider and result register
// depends on mnnd_pkg
module mnnd_dp #(
    parameter int MAX_POINTS = mnnd_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIM    = mnnd_pkg::DEF_MAX_DIM
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_mode,
    input  logic signed [mnnd_pkg::COORD_W-1:0]    i_coord_value,
    input  logic                                   i_end_of_point,
    input  logic                                   i_end_of_set,
    input  logic [$clog2(MAX_DIM+1)-1:0]           i_used_dims,
    input  mnnd_pkg::t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_DIM+1)-1:0]           i_k,
    input  logic [$clog2(MAX_POINTS*MAX_DIM)-1:0]  i_scan_addr,
    output mnnd_pkg::t_dp_stat                     o_stat,
    output logic [$clog2(MAX_POINTS+1)-1:0]        o_ref_cnt,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [mnnd_pkg::AVG_W-1:0]             o_avg_distance,
    output logic [mnnd_pkg::STATUS_W-1:0]          o_status
);
    import mnnd_pkg::*;

    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int KW     = $clog2(MAX_DIM + 1);
    localparam int KI     = $clog2(MAX_DIM);
    localparam int AW     = $clog2(MAX_POINTS * MAX_DIM);
    localparam int DEPTH  = MAX_POINTS * MAX_DIM;
    localparam int SQ_RAW = 2 * DIFF_W - 1 + $clog2(MAX_DIM);
    localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
    localparam int RW     = SQ_W / 2;

    // item latch
    logic                      r_mode;
    logic signed [COORD_W-1:0] r_value;
    logic                      r_eop;
    logic                      r_eos;

    // run state
    logic [KW-1:0]     r_ci;
    logic [CW-1:0]     r_ref_cnt;
    logic [QCNT_W-1:0] r_q_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;

    logic signed [COORD_W-1:0] r_qbuf [MAX_DIM];
    logic [COORD_W-1:0]        r_mem  [DEPTH];

    logic              room;
    logic              ci_used;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [COORD_W-1:0] wr_data;

    assign room    = r_ref_cnt < CW'(MAX_POINTS);
    assign ci_used = r_ci < i_used_dims;
    assign mem_we  = i_cmd.clr_wr || (i_cmd.item_write && !r_mode && room && ci_used);
    assign wr_addr = AW'(r_ref_cnt) * AW'(MAX_DIM) + (i_cmd.clr_wr ? AW'(i_k) : AW'(r_ci));
    assign wr_data = i_cmd.clr_wr ? '0 : r_value;

    assign o_ref_cnt        = r_ref_cnt;
    assign o_stat.mode      = r_mode;
    assign o_stat.end_point = r_eop;
    assign o_stat.end_set   = r_eos;
    assign o_stat.ci_zero   = (r_ci == '0);
    assign o_stat.room      = room;
    assign o_stat.ref_empty = (r_ref_cnt == '0);
    assign o_stat.empty     = (r_ref_cnt == '0) || (r_q_cnt == '0);
    assign o_stat.out_busy  = o_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= i_mode;
            r_value <= i_coord_value;
            r_eop   <= i_end_of_point || i_end_of_set;
            r_eos   <= i_end_of_set;
        end
    end

    // reference store
    logic [COORD_W-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_scan_addr];
        end
    end

    // query point buffer, zeroed at each query point's first coordinate and when a result is emitted
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_qbuf[i] <= '0;
            end
        end else if (i_cmd.item_write && r_mode) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                if (r_ci == '0) begin
                    r_qbuf[i] <= '0;
                end
            end
            if (ci_used) begin
                r_qbuf[r_ci[KI-1:0]] <= r_value;
            end
        end
    end

    // distance pipeline: read, difference, square, per-point sum, minimum
    logic              r_v1, r_fk1, r_lk1, r_fp1;
    logic [KI-1:0]     r_q1;
    logic              r_v2, r_fk2, r_lk2, r_fp2;
    logic [DIFF_W-1:0] r_abs2;
    logic              r_v3, r_fk3, r_lk3, r_fp3;
    logic [SQ_TERM_W-1:0] r_sq3;
    logic              r_v4, r_fp4;
    logic [SQ_W-1:0]   r_acc;
    logic [SQ_W-1:0]   r_best;
    logic signed [DIFF_W-1:0] diff;

    assign diff = DIFF_W'($signed(r_rdata)) - DIFF_W'(r_qbuf[r_q1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3 && r_lk3;
        end
        r_fk1  <= i_cmd.first_k;
        r_lk1  <= i_cmd.last_k;
        r_fp1  <= i_cmd.first_p;
        r_q1   <= i_k[KI-1:0];
        r_fk2  <= r_fk1;
        r_lk2  <= r_lk1;
        r_fp2  <= r_fp1;
        r_abs2 <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        r_fk3  <= r_fk2;
        r_lk3  <= r_lk2;
        r_fp3  <= r_fp2;
        r_sq3  <= r_abs2 * r_abs2;
        r_fp4  <= r_fp3;
        if (r_v3) begin
            r_acc <= r_fk3 ? SQ_W'(r_sq3) : r_acc + SQ_W'(r_sq3);
        end
        if (r_v4 && (r_fp4 || r_acc < r_best)) begin
            r_best <= r_acc;
        end
    end

    // bit-serial integer square root, one result bit per cycle
    logic [SQ_W-1:0] r_sx, r_sres, r_sbit;
    logic [SQ_W-1:0] s_trial;
    assign s_trial = r_sres + r_sbit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_sx   <= r_best;
            r_sres <= '0;
            r_sbit <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_sx >= s_trial) begin
                r_sx   <= r_sx - s_trial;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // restoring divider for sum / count, one quotient bit per cycle
    logic [SUM_W-1:0]  r_dq;
    logic [QCNT_W-1:0] r_drem;
    logic [QCNT_W:0]   d_trial;
    logic              d_ge;
    assign d_trial = {r_drem, r_dq[SUM_W-1]};
    assign d_ge    = d_trial >= {1'b0, r_q_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dq   <= r_sum;
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= d_ge ? QCNT_W'(d_trial - {1'b0, r_q_cnt}) : QCNT_W'(d_trial);
            r_dq   <= {r_dq[SUM_W-2:0], d_ge};
        end
    end

    // run counters and sum
    logic [SUM_W:0] sum_ext;
    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_sres[RW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci      <= '0;
            r_ref_cnt <= '0;
            r_q_cnt   <= '0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ci      <= '0;
            r_ref_cnt <= '0;
            r_q_cnt   <= '0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.item_write) begin
                if (r_eop) begin
                    r_ci <= '0;
                    if (!r_mode) begin
                        if (room) begin
                            r_ref_cnt <= r_ref_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end else if (r_ci < KW'(MAX_DIM)) begin
                    r_ci <= r_ci + KW'(1);
                end
            end
            if (i_cmd.accum) begin
                r_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                if (r_q_cnt != '1) begin
                    r_q_cnt <= r_q_cnt + QCNT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            if (o_stat.empty) begin
                o_avg_distance <= '0;
                o_status       <= STATUS_EMPTY;
            end else begin
                o_avg_distance <= (|r_dq[SUM_W-1:AVG_W]) ? '1 : r_dq[AVG_W-1:0];
                o_status       <= r_ovf ? STATUS_DROPPED : STATUS_OK;
            end
        end
    end

endmodule

FILE: rtl/mean_nearest_neighbor_distance.sv
// Mean nearest-neighbor distance between a reference and a query point cluster.
// Coordinates stream in on i_in (valid/ready), one signed Q8.16 coordinate per transfer,
// mode 0 for reference points and mode 1 for query points; end_of_point closes a
// point and end_of_set on a query coordinate closes the query set. Reference points
// go into an on-chip store of MAX_POINTS x MAX_DIM coordinates.
// Each coordinate is latched, decoded and written; the first coordinate of a reference point
// first has its row zeroed while the store has room, one entry a cycle.
// The last coordinate of a query point then starts a scan of the N stored reference points,
// D coordinates measured each (one per store read port cycle), a drain of the distance
// pipeline and R = 26 square-root steps at MAX_DIM = 8; the end of the query set adds
// a bit-serial division of the sum by the query count before the result is loaded.
// The result (avg_distance Q16.16, status) leaves on o_out from a result register;
// the block keeps taking coordinates while it waits, and only a following set end
// waits until the receiver has taken the previous result.
// Configuration registers axis_select and dimension_count are written through i_cfg_we,
// i_cfg_idx and i_cfg_data, by the user only while the block is idle (not enforced here).
// Synchronous active-low reset clears the counters, the sum and the flags; stored
// coordinates keep no reset value. No clearing pass is needed after reset.
// depends on mnnd_pkg, mnnd_if, mnnd_ctrl, mnnd_dp
module mean_nearest_neighbor_distance #(
    parameter int MAX_POINTS = mnnd_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIM    = mnnd_pkg::DEF_MAX_DIM
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mnnd_in_if.sink                            i_in,
    mnnd_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [mnnd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mnnd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mnnd_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_POINTS * MAX_DIM);

    logic [AXIS_W-1:0] r_axis;
    logic [DIM_W-1:0]  r_dims;
    logic [AXIS_W-1:0] cfg_axis;
    logic [KW-1:0]     used_dims;
    logic [KW-1:0]     k_lo, k_hi;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [CW-1:0]     ref_cnt;
    logic [KW-1:0]     k;
    logic [AW-1:0]     scan_addr;

    // axis code 3 behaves as all coordinates
    assign cfg_axis = (i_cfg_data[AXIS_W-1:0] == AXIS_SPARE) ? AXIS_ALL
                                                              : i_cfg_data[AXIS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_ALL;
            r_dims <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AXIS_SELECT:     r_axis <= cfg_axis;
                REG_DIMENSION_COUNT: r_dims <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_dims == '0) begin
            used_dims = KW'(1);
        end else if ((KW+DIM_W)'(r_dims) > (KW+DIM_W)'(MAX_DIM)) begin
            used_dims = KW'(MAX_DIM);
        end else begin
            used_dims = KW'(r_dims);
        end
        case (r_axis)
            AXIS_FIRST: begin
                k_lo = KW'(0);
                k_hi = KW'(1);
            end
            AXIS_SECOND: begin
                k_lo = KW'(1);
                k_hi = KW'(2);
            end
            default: begin
                k_lo = KW'(0);
                k_hi = used_dims;
            end
        endcase
    end

    mnnd_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIM    (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .i_ref_cnt   (ref_cnt),
        .i_k_lo      (k_lo),
        .i_k_hi      (k_hi),
        .o_cmd       (cmd),
        .o_k         (k),
        .o_scan_addr (scan_addr)
    );

    mnnd_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_in.mode),
        .i_coord_value  (i_in.coord_value),
        .i_end_of_point (i_in.end_of_point),
        .i_end_of_set   (i_in.end_of_set),
        .i_used_dims    (used_dims),
        .i_cmd          (cmd),
        .i_k            (k),
        .i_scan_addr    (scan_addr),
        .o_stat         (stat),
        .o_ref_cnt      (ref_cnt),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_avg_distance (o_out.avg_distance),
        .o_status       (o_out.status)
    );

endmodule
